// File: rtl/core/tcpf_pkg.sv
// shared types and codes for the two-class priority fifo
package tcpf_pkg;

    localparam logic [1:0] CMD_PUSH_NORMAL = 2'd0;
    localparam logic [1:0] CMD_PUSH_PRIO   = 2'd1;
    localparam logic [1:0] CMD_POP         = 2'd2;

    localparam logic [1:0] STATUS_PUSHED = 2'd0;
    localparam logic [1:0] STATUS_POPPED = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;
    localparam logic [1:0] STATUS_EMPTY  = 2'd3;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_POP,
        OP_INSERT
    } shift_op_t;

endpackage

// File: rtl/core/tcpf_cell.sv
// one storage cell of the ordered shift row
module tcpf_cell #(
    parameter int WIDTH = 32,
    parameter int POS_W = 5,
    parameter int INDEX = 0
) (
    input  logic                 clk,
    input  tcpf_pkg::shift_op_t  op,
    input  logic [POS_W-1:0]     ins_pos,
    input  logic [WIDTH-1:0]     new_word,
    input  logic [WIDTH-1:0]     left_word,
    input  logic [WIDTH-1:0]     right_word,
    output logic [WIDTH-1:0]     word
);

    logic [WIDTH-1:0] word_reg;
    logic [WIDTH-1:0] word_next;
    logic [POS_W-1:0] my_pos;

    assign my_pos = POS_W'(INDEX);

    always_comb
    begin
        word_next = word_reg;
        unique case (op)
            tcpf_pkg::OP_POP:
            begin
                word_next = right_word;
            end
            tcpf_pkg::OP_INSERT:
            begin
                if (my_pos == ins_pos)
                begin
                    word_next = new_word;
                end
                else if (my_pos > ins_pos)
                begin
                    word_next = left_word;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// File: rtl/core/two_class_priority_fifo_top.sv
// top level of the two-class priority fifo: control, counters and cell row
//
// Takes one command per clock cycle; busy is never raised. The answer to a
// command appears on status, data_out and occupancy with done high in the
// cycle right after start, for exactly one cycle, and cannot be held off by
// the receiver. Words sit in one row of DEPTH cells kept in leave order,
// priority words ahead of normal words: a pop shifts the whole row one cell
// toward the head, a push writes its cell and shifts the cells behind it one
// place back.
module two_class_priority_fifo_top #(
    parameter int DEPTH         = 16,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   cmd,
    input  logic [PAYLOAD_WIDTH-1:0]     payload,
    output logic                         done,
    output logic [1:0]                   status,
    output logic [PAYLOAD_WIDTH-1:0]     data_out,
    output logic [$clog2(DEPTH+1)-1:0]   occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] prio_reg;
    logic [CNT_W-1:0] prio_next;
    logic             done_reg;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic [PAYLOAD_WIDTH-1:0] data_reg;
    logic [PAYLOAD_WIDTH-1:0] data_next;
    logic [CNT_W-1:0] occ_reg;

    logic             is_push;
    logic             is_prio;
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] ins_pos;
    tcpf_pkg::shift_op_t op;
    logic [PAYLOAD_WIDTH-1:0] cell_word [DEPTH];

    assign busy    = 1'b0;
    assign is_push = (cmd == tcpf_pkg::CMD_PUSH_NORMAL) || (cmd == tcpf_pkg::CMD_PUSH_PRIO);
    assign is_prio = (cmd == tcpf_pkg::CMD_PUSH_PRIO);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign ins_pos = is_prio ? prio_reg : count_reg;

    always_comb
    begin
        op          = tcpf_pkg::OP_HOLD;
        count_next  = count_reg;
        prio_next   = prio_reg;
        status_next = tcpf_pkg::STATUS_PUSHED;
        data_next   = '0;
        if (is_push)
        begin
            if (full)
            begin
                status_next = tcpf_pkg::STATUS_FULL;
            end
            else
            begin
                op          = start ? tcpf_pkg::OP_INSERT : tcpf_pkg::OP_HOLD;
                count_next  = count_reg + 1'b1;
                if (is_prio)
                begin
                    prio_next = prio_reg + 1'b1;
                end
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = tcpf_pkg::STATUS_EMPTY;
            end
            else
            begin
                op          = start ? tcpf_pkg::OP_POP : tcpf_pkg::OP_HOLD;
                status_next = tcpf_pkg::STATUS_POPPED;
                data_next   = cell_word[0];
                count_next  = count_reg - 1'b1;
                if (prio_reg != '0)
                begin
                    prio_next = prio_reg - 1'b1;
                end
            end
        end
    end

    // ordered row of cells, head at index zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [PAYLOAD_WIDTH-1:0] left_word;
        logic [PAYLOAD_WIDTH-1:0] right_word;

        if (i == 0)
        begin : g_head
            assign left_word = payload;
        end
        else
        begin : g_body
            assign left_word = cell_word[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_word = '0;
        end
        else
        begin : g_inner
            assign right_word = cell_word[i+1];
        end

        tcpf_cell #(
            .WIDTH (PAYLOAD_WIDTH),
            .POS_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .op         (op),
            .ins_pos    (ins_pos),
            .new_word   (payload),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (cell_word[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            prio_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= start;
            if (start)
            begin
                count_reg <= count_next;
                prio_reg  <= prio_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            status_reg <= status_next;
            data_reg   <= data_next;
            occ_reg    <= count_next;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign data_out  = data_reg;
    assign occupancy = occ_reg;

endmodule
